@@ design/bqa_pkg.sv @@
// Shared constants, types and saturating helpers for the queue alternation block.
package bqa_pkg;

    localparam int unsigned NUM_QUEUES_DEF = 8;
    localparam int unsigned NUM_HEUR_DEF   = 4;

    localparam int unsigned MASK_W  = 8;
    localparam int unsigned BOOST_W = 16;
    localparam int unsigned HIDX_W  = 2;
    localparam int unsigned H_W     = 24;
    localparam int unsigned QIDX_W  = 3;
    localparam int unsigned PRIO_W  = 32;

    // Only queues named by the 8-bit masks and heuristics named by the 2-bit index exist.
    localparam int unsigned MAX_SEL_QUEUES = 8;
    localparam int unsigned MAX_SEL_HEUR   = 4;

    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_PREF_MASK = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOOST_AMT = 1'b1;

    localparam logic ACT_SELECT = 1'b0;
    localparam logic ACT_REPORT = 1'b1;

    localparam logic [BOOST_W-1:0] BOOST_RESET = 16'd1000;

    typedef logic signed [PRIO_W-1:0] t_prio;

    localparam t_prio PRIO_MAX = 32'sh7FFF_FFFF;
    localparam t_prio PRIO_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic              found;
        logic [QIDX_W-1:0] index;
    } t_pick;

    typedef struct packed {
        logic              action;
        logic [MASK_W-1:0] nonempty_mask;
        logic [HIDX_W-1:0] heuristic_index;
        logic [H_W-1:0]    h_value;
        logic              dead_end;
        logic              last_report;
    } t_req;

    typedef struct packed {
        logic              found;
        logic [QIDX_W-1:0] queue_index;
        logic              progress;
        logic              boosted;
    } t_rsp;

    function automatic t_prio prio_inc_sat(input t_prio p);
        return (p == PRIO_MAX) ? p : t_prio'(p + 32'sd1);
    endfunction

    function automatic t_prio prio_sub_sat(input t_prio p, input logic [BOOST_W-1:0] b);
        logic signed [PRIO_W:0] diff;
        diff = {p[PRIO_W-1], p} - {{(PRIO_W+1-BOOST_W){1'b0}}, b};
        // A borrow out of the sign bit means the result fell below the signed range.
        return (diff[PRIO_W] != diff[PRIO_W-1]) ? PRIO_MIN : t_prio'(diff[PRIO_W-1:0]);
    endfunction

endpackage

@@ design/bqa_req_if.sv @@
// Request channel: select and report items with a valid/ready handshake.
interface bqa_req_if;
    import bqa_pkg::*;

    logic              valid;
    logic              ready;
    logic              action;
    logic [MASK_W-1:0] nonempty_mask;
    logic [HIDX_W-1:0] heuristic_index;
    logic [H_W-1:0]    h_value;
    logic              dead_end;
    logic              last_report;

    modport source (
        output valid, action, nonempty_mask, heuristic_index, h_value, dead_end, last_report,
        input  ready
    );
    modport sink (
        input  valid, action, nonempty_mask, heuristic_index, h_value, dead_end, last_report,
        output ready
    );
endinterface

@@ design/bqa_rsp_if.sv @@
// Result channel: one result item per request with a valid/ready handshake.
interface bqa_rsp_if;
    import bqa_pkg::*;

    logic              valid;
    logic              ready;
    logic              found;
    logic [QIDX_W-1:0] queue_index;
    logic              progress;
    logic              boosted;

    modport source (
        output valid, found, queue_index, progress, boosted,
        input  ready
    );
    modport sink (
        input  valid, found, queue_index, progress, boosted,
        output ready
    );
endinterface

@@ design/boosted_queue_alternation.sv @@
// Boosted queue alternation: picks the next queue to pop and boosts preferred queues.
//
// Channels: i_req carries select items (action 0, nonempty_mask) and report items
// (action 1, heuristic_index, h_value, dead_end, last_report). o_rsp returns exactly
// one result item per request, in order: found and queue_index for a select, progress
// and boosted for a report. The configuration port writes preferred_mask (index 0) and
// boost_amount (index 1) on any clock with i_cfg_we high. The user must write them only
// while the block is idle; the block itself does not enforce this.
//
// A request passes the input register, then the selection and all state updates go
// combinationally into the result register. The block takes one item every cycle while
// o_rsp.ready stays high; the path that sets this is the compare tree over the
// registered queue priorities followed by the saturating priority update.
//
// Reset clears all priorities, the stored best values, the pending progress flag and
// both pipeline stages; preferred_mask resets to 0 and boost_amount to 1000.
// When the receiver holds o_rsp.ready low, the result stays in place, one more item
// is held in the input register, and then i_req.ready drops until the result is taken.
module boosted_queue_alternation #(
    parameter int unsigned NUM_QUEUES     = bqa_pkg::NUM_QUEUES_DEF,
    parameter int unsigned NUM_HEURISTICS = bqa_pkg::NUM_HEUR_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    bqa_req_if.sink                          i_req,
    bqa_rsp_if.source                        o_rsp,
    input  logic                             i_cfg_we,
    input  logic [bqa_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [bqa_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import bqa_pkg::*;

    localparam int unsigned NQ = (NUM_QUEUES < MAX_SEL_QUEUES) ? NUM_QUEUES : MAX_SEL_QUEUES;
    localparam int unsigned NH = (NUM_HEURISTICS < MAX_SEL_HEUR) ? NUM_HEURISTICS
                                                                 : MAX_SEL_HEUR;

    // Configuration.
    logic [MASK_W-1:0]  r_pref_mask;
    logic [BOOST_W-1:0] r_boost;

    // Search state.
    t_prio          r_prio [NQ];
    t_prio          n_prio [NQ];
    logic [H_W-1:0] r_best [NH];
    logic [H_W-1:0] n_best [NH];
    logic [NH-1:0]  r_best_set;
    logic [NH-1:0]  n_best_set;
    logic           r_pend;
    logic           n_pend;

    // Pipeline.
    logic r_in_valid;
    t_req r_in;
    logic r_out_valid;
    t_rsp r_out;
    t_rsp n_out;

    logic  advance;
    logic  out_free;
    t_pick pick;

    assign out_free    = !r_out_valid || o_rsp.ready;
    assign advance     = r_in_valid && out_free;
    assign i_req.ready = !r_in_valid || advance;

    bqa_pick #(
        .NUM_SEL (NQ)
    ) u_pick (
        .i_mask (r_in.nonempty_mask[NQ-1:0]),
        .i_prio (r_prio),
        .o_pick (pick)
    );

    always_comb begin
        logic           is_sel;
        logic           hidx_ok;
        logic [H_W-1:0] cur_best;
        logic           cur_set;
        logic           hit;
        logic           pend_now;
        logic           do_boost;

        is_sel   = (r_in.action == ACT_SELECT);
        cur_best = '0;
        cur_set  = 1'b0;
        for (int h = 0; h < int'(NH); h++) begin
            if (r_in.heuristic_index == HIDX_W'(h)) begin
                cur_best = r_best[h];
                cur_set  = r_best_set[h];
            end
        end
        hidx_ok  = int'(r_in.heuristic_index) < int'(NH);
        hit      = !is_sel && !r_in.dead_end && hidx_ok
                   && (!cur_set || r_in.h_value < cur_best);
        pend_now = r_pend || hit;
        do_boost = !is_sel && r_in.last_report && pend_now;

        n_best     = r_best;
        n_best_set = r_best_set;
        for (int h = 0; h < int'(NH); h++) begin
            if (hit && r_in.heuristic_index == HIDX_W'(h)) begin
                n_best[h]     = r_in.h_value;
                n_best_set[h] = 1'b1;
            end
        end

        // A select and a boost never fall in the same item.
        n_prio = r_prio;
        for (int q = 0; q < int'(NQ); q++) begin
            if (is_sel && pick.found && pick.index == QIDX_W'(q)) begin
                n_prio[q] = prio_inc_sat(r_prio[q]);
            end else if (do_boost && r_pref_mask[q]) begin
                n_prio[q] = prio_sub_sat(r_prio[q], r_boost);
            end
        end

        if (is_sel) begin
            n_pend = r_pend;
        end else begin
            n_pend = r_in.last_report ? 1'b0 : pend_now;
        end

        n_out.found       = is_sel && pick.found;
        n_out.queue_index = (is_sel && pick.found) ? pick.index : '0;
        n_out.progress    = !is_sel && pend_now;
        n_out.boosted     = do_boost;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pref_mask <= '0;
            r_boost     <= BOOST_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_PREF_MASK: r_pref_mask <= i_cfg_data[MASK_W-1:0];
                CFG_BOOST_AMT: r_boost     <= i_cfg_data[BOOST_W-1:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int q = 0; q < int'(NQ); q++) begin
                r_prio[q] <= '0;
            end
            for (int h = 0; h < int'(NH); h++) begin
                r_best[h] <= '0;
            end
            r_best_set  <= '0;
            r_pend      <= 1'b0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_prio     <= n_prio;
                r_best     <= n_best;
                r_best_set <= n_best_set;
                r_pend     <= n_pend;
            end
            if (i_req.ready) begin
                r_in_valid <= i_req.valid;
            end
            if (out_free) begin
                r_out_valid <= advance;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in.action          <= i_req.action;
            r_in.nonempty_mask   <= i_req.nonempty_mask;
            r_in.heuristic_index <= i_req.heuristic_index;
            r_in.h_value         <= i_req.h_value;
            r_in.dead_end        <= i_req.dead_end;
            r_in.last_report     <= i_req.last_report;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.found       = r_out.found;
    assign o_rsp.queue_index = r_out.queue_index;
    assign o_rsp.progress    = r_out.progress;
    assign o_rsp.boosted     = r_out.boosted;

    // A boost is only ever reported together with progress.
    a_boost_needs_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.boosted) |-> r_out.progress)
        else $error("boost reported without progress");

    // A select result never carries report flags.
    a_select_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.found) |-> (!r_out.progress && !r_out.boosted))
        else $error("select result carries report flags");

    // Pending progress never outlives the last report of a state.
    a_pend_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_in.action == ACT_REPORT && r_in.last_report) |=> !r_pend)
        else $error("progress still pending after last report");

    // Back pressure only appears with both stages occupied.
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_req.ready |-> (r_in_valid && r_out_valid))
        else $error("input stalled with a free stage");

    // A stalled result holds while the receiver is not ready.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_rsp.ready) |=> (r_out_valid && $stable(r_out)))
        else $error("stalled result changed");

endmodule

@@ design/bqa_pick.sv @@
// Lowest-priority queue selection among the non-empty queues, lowest index on ties.
module bqa_pick #(
    parameter int unsigned NUM_SEL = bqa_pkg::MAX_SEL_QUEUES
) (
    input  logic [NUM_SEL-1:0] i_mask,
    input  bqa_pkg::t_prio     i_prio [NUM_SEL],
    output bqa_pkg::t_pick     o_pick
);
    import bqa_pkg::*;

    always_comb begin
        t_prio best;
        best   = '0;
        o_pick = '0;
        // Strict less-than keeps the earlier queue when priorities tie.
        for (int q = 0; q < int'(NUM_SEL); q++) begin
            if (i_mask[q] && (!o_pick.found || i_prio[q] < best)) begin
                o_pick.found = 1'b1;
                o_pick.index = QIDX_W'(q);
                best         = i_prio[q];
            end
        end
    end

endmodule

@@ tb/boosted_queue_alternation_tb.sv @@
// Self-checking testbench for the boosted queue alternation block.
module boosted_queue_alternation_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bqa_pkg::*;

    localparam int HEUR_COUNT  = 4;
    localparam int QUEUE_COUNT = 8;
    localparam int STALL_LIMIT = 1000;
    localparam int SETTLE_CYC  = 4;
    localparam int SEG_ITEMS   = 234;
    localparam int BOOST_RUN   = 40;

    typedef struct {
        t_req req;
        logic fixed;
        t_rsp rsp;
    } t_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    bqa_req_if req_if ();
    bqa_rsp_if rsp_if ();

    boosted_queue_alternation u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_if),
        .o_rsp       (rsp_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Predicted block state and registers.
    t_prio          prio_m [QUEUE_COUNT];
    logic [H_W-1:0] best_m [HEUR_COUNT];
    logic           best_ok [HEUR_COUNT];
    logic           pend_m;
    logic [MASK_W-1:0]  pref_m;
    logic [BOOST_W-1:0] boost_m;

    t_row plan_q [$];
    t_rsp outcome_q [$];

    int send_idle_pct = 32;
    int recv_idle_pct = 64;
    int n_err = 0;
    int n_req = 0;
    int n_rsp = 0;
    int n_boost = 0;
    int n_none = 0;
    int stall_cnt = 0;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic t_rsp alternate_and_boost(input t_req r);
        t_rsp   o;
        int     pick;
        int     q;
        int     hi;
        longint v;
        o = '0;
        pick = -1;
        if (r.action == ACT_SELECT) begin
            for (q = 0; q < QUEUE_COUNT; q++) begin
                if (r.nonempty_mask[q] && (pick < 0 || prio_m[q] < prio_m[pick]))
                    pick = q;
            end
            if (pick >= 0) begin
                if (prio_m[pick] != PRIO_MAX)
                    prio_m[pick] = prio_m[pick] + 1;
                o.found = 1'b1;
                o.queue_index = QIDX_W'(pick);
            end
        end else begin
            hi = int'(r.heuristic_index);
            if (!r.dead_end && hi < HEUR_COUNT) begin
                if (!best_ok[hi] || r.h_value < best_m[hi]) begin
                    best_m[hi] = r.h_value;
                    best_ok[hi] = 1'b1;
                    pend_m = 1'b1;
                end
            end
            o.progress = pend_m;
            if (r.last_report) begin
                if (pend_m) begin
                    for (q = 0; q < QUEUE_COUNT; q++) begin
                        if (pref_m[q]) begin
                            v = longint'(prio_m[q]) - longint'(boost_m);
                            if (v < longint'(PRIO_MIN))
                                v = longint'(PRIO_MIN);
                            prio_m[q] = t_prio'(v);
                        end
                    end
                    o.boosted = 1'b1;
                end
                pend_m = 1'b0;
            end
        end
        return o;
    endfunction

    function automatic t_row sel_row(input logic [MASK_W-1:0] mask, input logic fixed,
                                     input logic found, input logic [QIDX_W-1:0] qi);
        t_row row;
        row.req = '0;
        row.req.action = ACT_SELECT;
        row.req.nonempty_mask = mask;
        row.fixed = fixed;
        row.rsp = '{found: found, queue_index: qi, progress: 1'b0, boosted: 1'b0};
        return row;
    endfunction

    function automatic t_row rep_row(input logic [HIDX_W-1:0] hi, input logic [H_W-1:0] h,
                                     input logic dead, input logic last, input logic fixed,
                                     input logic prog, input logic bst);
        t_row row;
        row.req = '0;
        row.req.action = ACT_REPORT;
        row.req.heuristic_index = hi;
        row.req.h_value = h;
        row.req.dead_end = dead;
        row.req.last_report = last;
        row.fixed = fixed;
        row.rsp = '{found: 1'b0, queue_index: '0, progress: prog, boosted: bst};
        return row;
    endfunction

    function automatic logic [MASK_W-1:0] rand_mask();
        int roll;
        roll = $urandom_range(99);
        if (roll < 5)
            return '0;
        if (roll < 15)
            return '1;
        return MASK_W'($urandom_range(255));
    endfunction

    // Mostly values at or just under the stored best, so that progress keeps happening.
    function automatic logic [H_W-1:0] pick_h(input logic [HIDX_W-1:0] hi);
        int roll;
        roll = $urandom_range(99);
        if (roll < 10 || !best_ok[hi])
            return H_W'($urandom);
        if (roll < 15)
            return '1;
        return (best_m[hi] > 2) ? best_m[hi] - H_W'($urandom_range(0, 2)) : best_m[hi];
    endfunction

    task automatic check_field(input string name, input logic [3:0] want,
                               input logic [3:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_err++;
        end
    endtask

    task automatic push_req(input t_row row);
        plan_q.insert(plan_q.size(), row);
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid           <= 1'b1;
        req_if.action          <= row.req.action;
        req_if.nonempty_mask   <= row.req.nonempty_mask;
        req_if.heuristic_index <= row.req.heuristic_index;
        req_if.h_value         <= row.req.h_value;
        req_if.dead_end        <= row.req.dead_end;
        req_if.last_report     <= row.req.last_report;
        @(posedge i_clk);
        while (!req_if.ready)
            @(posedge i_clk);
    endtask

    // Either the plan or the outcome queue still holds the last item at its acceptance edge.
    task automatic settle();
        req_if.valid <= 1'b0;
        while (plan_q.size() != 0 || outcome_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic program_regs(input logic [MASK_W-1:0] pref, input logic [BOOST_W-1:0] amt);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_PREF_MASK;
        i_cfg_data  <= CFG_DATA_W'(pref);
        @(posedge i_clk);
        i_cfg_index <= CFG_BOOST_AMT;
        i_cfg_data  <= amt;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic run_random(input int count);
        int          sent;
        int          k;
        int          j;
        int          nsel;
        logic [HIDX_W-1:0] hi;
        sent = 0;
        while (sent < count) begin
            nsel = $urandom_range(0, 2);
            for (j = 0; j < nsel; j++) begin
                push_req(sel_row(rand_mask(), 1'b0, 1'b0, '0));
                sent++;
            end
            if ($urandom_range(99) < 15) begin
                // Stray report with random flags breaks the state boundaries.
                push_req(rep_row(HIDX_W'($urandom), H_W'($urandom), 1'($urandom),
                                 1'($urandom), 1'b0, 1'b0, 1'b0));
                sent++;
            end else begin
                k = $urandom_range(1, 4);
                for (j = 0; j < k; j++) begin
                    hi = HIDX_W'($urandom_range(HEUR_COUNT - 1));
                    push_req(rep_row(hi, pick_h(hi), $urandom_range(9) == 0, j == k - 1,
                                     1'b0, 1'b0, 1'b0));
                    sent++;
                    if (j < k - 1 && $urandom_range(9) == 0) begin
                        push_req(sel_row(rand_mask(), 1'b0, 1'b0, '0));
                        sent++;
                    end
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        t_req r;
        t_rsp want;
        t_row row;
        logic moved;
        if (!i_rst_n) begin
            foreach (prio_m[q]) prio_m[q] = '0;
            foreach (best_m[h]) begin
                best_m[h] = '0;
                best_ok[h] = 1'b0;
            end
            pend_m = 1'b0;
            pref_m = '0;
            boost_m = BOOST_RESET;
        end else begin
            moved = 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_PREF_MASK: pref_m = i_cfg_data[MASK_W-1:0];
                    CFG_BOOST_AMT: boost_m = i_cfg_data[BOOST_W-1:0];
                    default: ;
                endcase
            end
            if (rsp_if.valid && rsp_if.ready) begin
                moved = 1'b1;
                n_rsp++;
                if (outcome_q.size() == 0) begin
                    $error("result item arrived with no request outstanding");
                    n_err++;
                end else begin
                    want = outcome_q.pop_front();
                    check_field("found", 4'(want.found), 4'(rsp_if.found));
                    check_field("queue_index", 4'(want.queue_index), 4'(rsp_if.queue_index));
                    check_field("progress", 4'(want.progress), 4'(rsp_if.progress));
                    check_field("boosted", 4'(want.boosted), 4'(rsp_if.boosted));
                    if (rsp_if.boosted === 1'b1)
                        n_boost++;
                end
            end
            if (req_if.valid && req_if.ready) begin
                moved = 1'b1;
                n_req++;
                r = '{req_if.action, req_if.nonempty_mask, req_if.heuristic_index,
                      req_if.h_value, req_if.dead_end, req_if.last_report};
                want = alternate_and_boost(r);
                if (r.action == ACT_SELECT && !want.found)
                    n_none++;
                row = plan_q.pop_front();
                if (row.fixed)
                    want = row.rsp;
                outcome_q.insert(outcome_q.size(), want);
            end
            stall_cnt = moved ? 0 : stall_cnt + 1;
            if (stall_cnt >= STALL_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        t_row        steer_rows [$];
        logic [MASK_W-1:0]  pref_set [6];
        logic [BOOST_W-1:0] boost_set [6];
        int          n;
        int          seg;
        i_rst_n                = 1'b0;
        i_cfg_we               = 1'b0;
        i_cfg_index            = CFG_PREF_MASK;
        i_cfg_data             = '0;
        req_if.valid           = 1'b0;
        req_if.action          = ACT_SELECT;
        req_if.nonempty_mask   = '0;
        req_if.heuristic_index = '0;
        req_if.h_value         = '0;
        req_if.dead_end        = 1'b0;
        req_if.last_report     = 1'b0;
        rsp_if.ready           = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Expected values are given only where reset state makes them obvious.
        steer_rows = '{
            sel_row(8'h00, 1'b1, 1'b0, 3'd0),
            sel_row(8'hFF, 1'b1, 1'b1, 3'd0),
            sel_row(8'hFF, 1'b1, 1'b1, 3'd1),
            sel_row(8'h80, 1'b1, 1'b1, 3'd7),
            sel_row(8'hFE, 1'b0, 1'b0, 3'd0),
            rep_row(2'd0, 24'hFFFFFF, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0),
            rep_row(2'd0, 24'hFFFFFF, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1),
            rep_row(2'd0, 24'hFFFFFF, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0),
            rep_row(2'd3, 24'h000000, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0),
            rep_row(2'd3, 24'hFFFFF0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0),
            sel_row(8'h01, 1'b1, 1'b1, 3'd0),
            rep_row(2'd1, 24'hFFFF00, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1),
            rep_row(2'd2, 24'h000000, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0),
            rep_row(2'd2, 24'h000000, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1),
            rep_row(2'd1, 24'hFFFF01, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0),
            rep_row(2'd1, 24'hFFFEFF, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0),
            sel_row(8'h03, 1'b0, 1'b0, 3'd0),
            rep_row(2'd3, 24'hFFFFF0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0),
            sel_row(8'hAA, 1'b0, 1'b0, 3'd0),
            sel_row(8'h55, 1'b0, 1'b0, 3'd0)
        };
        foreach (steer_rows[i])
            push_req(steer_rows[i]);
        settle();

        // A run of maximum boosts on the low queues drives them far below the others.
        program_regs(8'h0F, 16'hFFFF);
        for (n = 0; n < BOOST_RUN; n++)
            push_req(rep_row(2'd0, 24'hFFFFFE - H_W'(n), 1'b0, 1'b1, 1'b0, 1'b0, 1'b0));
        for (n = 0; n < 6; n++)
            push_req(sel_row(8'hFF, 1'b0, 1'b0, 3'd0));

        pref_set  = '{8'hFF, 8'h00, 8'hAA, MASK_W'($urandom), 8'h55, MASK_W'($urandom)};
        boost_set = '{16'd0, 16'hFFFF, 16'd1, BOOST_W'($urandom), 16'd1000, BOOST_W'($urandom)};
        for (seg = 0; seg < 6; seg++) begin
            if (seg == 2) begin
                send_idle_pct = 64;
                recv_idle_pct = 32;
            end
            if (seg == 4) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            settle();
            program_regs(pref_set[seg], boost_set[seg]);
            run_random(SEG_ITEMS);
        end
        settle();

        $display("Covered %0d request items and %0d result items under eight register settings,",
                 n_req, n_rsp);
        $display("with %0d boosts and %0d selects that saw every queue empty.", n_boost, n_none);
        if (n_err == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
